FILE: rtl/pebo_pkg.sv
package pebo_pkg;

  // Default coordinate width and edge counter modulus.
  localparam int COORD_BITS = 16;
  localparam int MAX_EDGES  = 1024;

  // Width of the edge index carried on the result channel.
  localparam int IDX_BITS = 10;

  // Configuration register map.
  localparam int CFG_ADDR_BITS = 2;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MIN_Y = 2'd1,
    REG_BOX_MAX_X = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } cfg_reg_e;

  // Tag that travels with an edge through the pipeline.
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic                closing;
  } edge_tag_t;

endpackage

FILE: rtl/pebo_in_if.sv
interface pebo_in_if #(
  parameter int CoordBits = pebo_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] vertex_x;
  logic signed [CoordBits-1:0] vertex_y;
  logic                        last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

FILE: rtl/pebo_out_if.sv
interface pebo_out_if;
  import pebo_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] edge_index;
  logic                touches_box;
  logic                last_result;

  modport source (output valid, output edge_index, output touches_box, output last_result,
                  input ready);
  modport sink (input valid, input edge_index, input touches_box, input last_result,
                output ready);
endinterface

FILE: rtl/polygon_edge_box_overlap.sv
// Channel   Dir  Word contents                              Handshake
// in_vtx    in   vertex_x, vertex_y, last_vertex           valid/ready
// out_res   out  edge_index, touches_box, last_result      valid/ready
// cfg_*     in   cfg_addr selects box register, cfg_wdata  cfg_we, no stall
//
// One vertex word is taken per cycle while in_ready is high. A final vertex that follows
// at least one other vertex yields its own edge and the wrap edge, so in_ready stays low until the edge
// register issues the wrap edge. A result passes the edge register, the product
// register and the result register in turn. Reset is synchronous and active
// low; it clears the box registers to zero and empties every stage. When
// out_ready is low the stages fill up behind the result register and in_ready
// falls only once the edge register can no longer move.
module polygon_edge_box_overlap #(
  parameter int CoordBits = pebo_pkg::COORD_BITS,
  parameter int MaxEdges  = pebo_pkg::MAX_EDGES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pebo_in_if.sink                            in_vtx,
  pebo_out_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [pebo_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CoordBits-1:0]               cfg_wdata
);
  import pebo_pkg::*;

  localparam int PW = 2 * CoordBits + 2;

  // Box registers. The user must change them only while the block is idle; the block
  // itself does not enforce this. The product stage reads them live.
  logic signed [CoordBits-1:0] box_min_x_r, box_min_x_nxt;
  logic signed [CoordBits-1:0] box_min_y_r, box_min_y_nxt;
  logic signed [CoordBits-1:0] box_max_x_r, box_max_x_nxt;
  logic signed [CoordBits-1:0] box_max_y_r, box_max_y_nxt;

  always_comb begin
    box_min_x_nxt = box_min_x_r;
    box_min_y_nxt = box_min_y_r;
    box_max_x_nxt = box_max_x_r;
    box_max_y_nxt = box_max_y_r;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_addr))
        REG_BOX_MIN_X: box_min_x_nxt = $signed(cfg_wdata);
        REG_BOX_MIN_Y: box_min_y_nxt = $signed(cfg_wdata);
        REG_BOX_MAX_X: box_max_x_nxt = $signed(cfg_wdata);
        REG_BOX_MAX_Y: box_max_y_nxt = $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_x_r <= '0;
      box_min_y_r <= '0;
      box_max_x_r <= '0;
      box_max_y_r <= '0;
    end else begin
      box_min_x_r <= box_min_x_nxt;
      box_min_y_r <= box_min_y_nxt;
      box_max_x_r <= box_max_x_nxt;
      box_max_y_r <= box_max_y_nxt;
    end
  end

  // Edge register: endpoints and tag of the edge being tested.
  logic                        e_valid;
  logic signed [CoordBits-1:0] e_px, e_py, e_qx, e_qy;
  edge_tag_t                   e_tag;

  // Product register: the four partial products and the endpoint/interval flag.
  logic                        s2_ready, s3_ready, p_valid, p_near;
  logic signed [PW-1:0]        pa_min, pa_max, pb_min, pb_max;
  edge_tag_t                   p_tag;

  pebo_edge_gen #(
    .CoordBits(CoordBits),
    .MaxEdges (MaxEdges)
  ) u_edge_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (in_vtx),
    .s2_ready(s2_ready),
    .e_valid (e_valid),
    .e_px    (e_px),
    .e_py    (e_py),
    .e_qx    (e_qx),
    .e_qy    (e_qy),
    .e_tag   (e_tag)
  );

  pebo_prod #(
    .CoordBits(CoordBits)
  ) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .e_valid  (e_valid),
    .e_px     (e_px),
    .e_py     (e_py),
    .e_qx     (e_qx),
    .e_qy     (e_qy),
    .e_tag    (e_tag),
    .box_min_x(box_min_x_r),
    .box_min_y(box_min_y_r),
    .box_max_x(box_max_x_r),
    .box_max_y(box_max_y_r),
    .s2_ready (s2_ready),
    .s3_ready (s3_ready),
    .p_valid  (p_valid),
    .pa_min   (pa_min),
    .pa_max   (pa_max),
    .pb_min   (pb_min),
    .pb_max   (pb_max),
    .p_near   (p_near),
    .p_tag    (p_tag)
  );

  pebo_decide #(
    .CoordBits(CoordBits)
  ) u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .p_valid (p_valid),
    .pa_min  (pa_min),
    .pa_max  (pa_max),
    .pb_min  (pb_min),
    .pb_max  (pb_max),
    .p_near  (p_near),
    .p_tag   (p_tag),
    .s3_ready(s3_ready),
    .out_res (out_res)
  );
endmodule

FILE: rtl/pebo_edge_gen.sv
module pebo_edge_gen #(
  parameter int CoordBits = pebo_pkg::COORD_BITS,
  parameter int MaxEdges  = pebo_pkg::MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pebo_in_if.sink                     in_vtx,
  input  logic                        s2_ready,
  output logic                        e_valid,
  output logic signed [CoordBits-1:0] e_px,
  output logic signed [CoordBits-1:0] e_py,
  output logic signed [CoordBits-1:0] e_qx,
  output logic signed [CoordBits-1:0] e_qy,
  output pebo_pkg::edge_tag_t         e_tag
);
  import pebo_pkg::*;

  localparam int CntBits = $clog2(MaxEdges);

  logic signed [CoordBits-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [CoordBits-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [CntBits-1:0]          cnt_r, cnt_nxt, cnt_inc;
  logic                        have_first_r, have_first_nxt;
  logic                        pend_r, pend_nxt;
  logic                        ev_r, ev_nxt;
  logic signed [CoordBits-1:0] px_r, px_nxt, py_r, py_nxt, qx_r, qx_nxt, qy_r, qy_nxt;
  edge_tag_t                   tag_r, tag_nxt;
  logic                        s1_free;
  logic                        acc;

  assign s1_free      = !ev_r || s2_ready;
  assign in_vtx.ready = !pend_r && s1_free;
  assign acc          = in_vtx.valid && in_vtx.ready;
  assign cnt_inc      = (cnt_r == CntBits'(MaxEdges - 1)) ? '0 : cnt_r + 1'b1;

  always_comb begin
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    cnt_nxt        = cnt_r;
    have_first_nxt = have_first_r;
    pend_nxt       = pend_r;
    ev_nxt         = s1_free ? 1'b0 : ev_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    tag_nxt        = tag_r;
    if (pend_r && s1_free) begin
      // Wrap edge from the final vertex back to the first one.
      ev_nxt         = 1'b1;
      px_nxt         = prev_x_r;
      py_nxt         = prev_y_r;
      qx_nxt         = first_x_r;
      qy_nxt         = first_y_r;
      tag_nxt        = '{idx: IDX_BITS'(cnt_r), closing: 1'b1};
      pend_nxt       = 1'b0;
      have_first_nxt = 1'b0;
      cnt_nxt        = '0;
    end else if (acc) begin
      prev_x_nxt = in_vtx.vertex_x;
      prev_y_nxt = in_vtx.vertex_y;
      if (!have_first_r) begin
        first_x_nxt = in_vtx.vertex_x;
        first_y_nxt = in_vtx.vertex_y;
        cnt_nxt     = '0;
        if (in_vtx.last_vertex) begin
          // A lone vertex closes onto itself.
          ev_nxt  = 1'b1;
          px_nxt  = in_vtx.vertex_x;
          py_nxt  = in_vtx.vertex_y;
          qx_nxt  = in_vtx.vertex_x;
          qy_nxt  = in_vtx.vertex_y;
          tag_nxt = '{idx: '0, closing: 1'b1};
        end else begin
          have_first_nxt = 1'b1;
        end
      end else begin
        ev_nxt   = 1'b1;
        px_nxt   = prev_x_r;
        py_nxt   = prev_y_r;
        qx_nxt   = in_vtx.vertex_x;
        qy_nxt   = in_vtx.vertex_y;
        tag_nxt  = '{idx: IDX_BITS'(cnt_r), closing: 1'b0};
        cnt_nxt  = cnt_inc;
        pend_nxt = in_vtx.last_vertex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      have_first_r <= 1'b0;
      pend_r       <= 1'b0;
      ev_r         <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      have_first_r <= have_first_nxt;
      pend_r       <= pend_nxt;
      ev_r         <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    tag_r     <= tag_nxt;
  end

  assign e_valid = ev_r;
  assign e_px    = px_r;
  assign e_py    = py_r;
  assign e_qx    = qx_r;
  assign e_qy    = qy_r;
  assign e_tag   = tag_r;
endmodule

FILE: rtl/pebo_prod.sv
module pebo_prod #(
  parameter int CoordBits = pebo_pkg::COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            e_valid,
  input  logic signed [CoordBits-1:0]     e_px,
  input  logic signed [CoordBits-1:0]     e_py,
  input  logic signed [CoordBits-1:0]     e_qx,
  input  logic signed [CoordBits-1:0]     e_qy,
  input  pebo_pkg::edge_tag_t             e_tag,
  input  logic signed [CoordBits-1:0]     box_min_x,
  input  logic signed [CoordBits-1:0]     box_min_y,
  input  logic signed [CoordBits-1:0]     box_max_x,
  input  logic signed [CoordBits-1:0]     box_max_y,
  output logic                            s2_ready,
  input  logic                            s3_ready,
  output logic                            p_valid,
  output logic signed [2*CoordBits+1:0]   pa_min,
  output logic signed [2*CoordBits+1:0]   pa_max,
  output logic signed [2*CoordBits+1:0]   pb_min,
  output logic signed [2*CoordBits+1:0]   pb_max,
  output logic                            p_near,
  output pebo_pkg::edge_tag_t             p_tag
);
  import pebo_pkg::*;

  localparam int DW = CoordBits + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] a, b, dx_min, dx_max, dy_min, dy_max;
  logic signed [PW-1:0] pa_min_r, pa_min_nxt, pa_max_r, pa_max_nxt;
  logic signed [PW-1:0] pb_min_r, pb_min_nxt, pb_max_r, pb_max_nxt;
  logic                 near_r, near_nxt;
  edge_tag_t            tag_r;
  logic                 pv_r, pv_nxt;
  logic                 in_p, in_q, ovl;
  logic                 load;

  // Line coefficients and corner offsets, one bit wider than a coordinate.
  assign a      = DW'(e_py) - DW'(e_qy);
  assign b      = DW'(e_qx) - DW'(e_px);
  assign dx_min = DW'(box_min_x) - DW'(e_px);
  assign dx_max = DW'(box_max_x) - DW'(e_px);
  assign dy_min = DW'(box_min_y) - DW'(e_py);
  assign dy_max = DW'(box_max_y) - DW'(e_py);

  assign pa_min_nxt = a * dx_min;
  assign pa_max_nxt = a * dx_max;
  assign pb_min_nxt = b * dy_min;
  assign pb_max_nxt = b * dy_max;

  // Endpoint and interval tests, taken exactly as written even for an inverted box.
  assign in_p = ((box_min_x <= e_px) == (e_px <= box_max_x)) &&
                ((box_min_y <= e_py) == (e_py <= box_max_y));
  assign in_q = ((box_min_x <= e_qx) == (e_qx <= box_max_x)) &&
                ((box_min_y <= e_qy) == (e_qy <= box_max_y));
  assign ovl  = ((e_px <= box_max_x) == (box_min_x <= e_qx)) &&
                ((e_py <= box_max_y) == (box_min_y <= e_qy));
  assign near_nxt = in_p || in_q || ovl;

  assign s2_ready = !pv_r || s3_ready;
  assign load     = s2_ready && e_valid;
  assign pv_nxt   = s2_ready ? e_valid : pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pa_min_r <= pa_min_nxt;
      pa_max_r <= pa_max_nxt;
      pb_min_r <= pb_min_nxt;
      pb_max_r <= pb_max_nxt;
      near_r   <= near_nxt;
      tag_r    <= e_tag;
    end
  end

  assign p_valid = pv_r;
  assign pa_min  = pa_min_r;
  assign pa_max  = pa_max_r;
  assign pb_min  = pb_min_r;
  assign pb_max  = pb_max_r;
  assign p_near  = near_r;
  assign p_tag   = tag_r;
endmodule

FILE: rtl/pebo_decide.sv
module pebo_decide #(
  parameter int CoordBits = pebo_pkg::COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          p_valid,
  input  logic signed [2*CoordBits+1:0] pa_min,
  input  logic signed [2*CoordBits+1:0] pa_max,
  input  logic signed [2*CoordBits+1:0] pb_min,
  input  logic signed [2*CoordBits+1:0] pb_max,
  input  logic                          p_near,
  input  pebo_pkg::edge_tag_t           p_tag,
  output logic                          s3_ready,
  pebo_out_if.source                    out_res
);
  import pebo_pkg::*;

  localparam int SW = 2 * CoordBits + 3;

  logic signed [SW-1:0] c1, c2, c3, c4;
  logic [1:0]           g1, g2, g3, g4;
  logic                 ov_r, ov_nxt;
  logic                 touch_r, touch_nxt;
  edge_tag_t            tag_r;
  logic                 load;

  // Exact line value at the four corners, in the order of the reference corners.
  assign c1 = SW'(pa_min) + SW'(pb_min);
  assign c2 = SW'(pa_min) + SW'(pb_max);
  assign c3 = SW'(pa_max) + SW'(pb_max);
  assign c4 = SW'(pa_max) + SW'(pb_min);

  // Sign code: {negative, zero}.
  assign g1 = {c1[SW-1], c1 == '0};
  assign g2 = {c2[SW-1], c2 == '0};
  assign g3 = {c3[SW-1], c3 == '0};
  assign g4 = {c4[SW-1], c4 == '0};

  assign touch_nxt = !((g1 == g2) && (g1 == g3) && (g1 == g4)) && p_near;

  assign s3_ready = !ov_r || out_res.ready;
  assign load     = s3_ready && p_valid;
  assign ov_nxt   = s3_ready ? p_valid : ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      touch_r <= touch_nxt;
      tag_r   <= p_tag;
    end
  end

  assign out_res.valid       = ov_r;
  assign out_res.edge_index  = tag_r.idx;
  assign out_res.touches_box = touch_r;
  assign out_res.last_result = tag_r.closing;
endmodule

FILE: rtl/pebo_checker.sv
module pebo_checker #(
  parameter int IdxBits = pebo_pkg::IDX_BITS
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [IdxBits-1:0] out_index,
  input logic               out_touch,
  input logic               out_last
);
  // The pipeline comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result word valid right after reset");

  // The input only stalls for the wrap edge of a final vertex or a full pipeline. A wrap
  // edge that is still owed keeps the input stalled until the edge register can move.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready) ||
                  $past(in_valid && in_ready && in_last) || $past(!in_ready))
    else $error("input stalled without a wrap edge or output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_touch) && $stable(out_last))
    else $error("result word changed while stalled");
endmodule

bind polygon_edge_box_overlap pebo_checker u_pebo_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_vtx.valid),
  .in_ready (in_vtx.ready),
  .in_last  (in_vtx.last_vertex),
  .out_valid(out_res.valid),
  .out_ready(out_res.ready),
  .out_index(out_res.edge_index),
  .out_touch(out_res.touches_box),
  .out_last (out_res.last_result)
);

FILE: sim/pebo_tb_pkg.sv
package pebo_tb_pkg;
  import pebo_pkg::*;

  typedef struct {
    logic [IDX_BITS-1:0] edge_index;
    bit                  touches;
    bit                  closing;
  } edge_result_t;

  // Tracks the polygon that is streaming in, works out the touch result of every edge it
  // closes and compares each result word from the block against the oldest one pending.
  class edge_touch_scoreboard;
    longint       box_reg[4];
    longint       first_x, first_y, prev_x, prev_y;
    int unsigned  edge_count;
    bit           have_first;
    edge_result_t expected_edges[$];
    int unsigned  mismatches;

    function new();
      foreach (box_reg[i]) box_reg[i] = 0;
      first_x = 0;
      first_y = 0;
      prev_x = 0;
      prev_y = 0;
      edge_count = 0;
      have_first = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [COORD_BITS-1:0] v);
      box_reg[int'(r)] = longint'($signed(v));
    endfunction

    function int line_sign(longint a, longint dx, longint b, longint dy);
      longint s;
      s = a * dx + b * dy;
      return (s > 0) ? 1 : ((s < 0) ? -1 : 0);
    endfunction

    // The box comparisons are taken literally, so an inverted box behaves as the
    // equalities say rather than as an empty region.
    function bit point_in_box(longint x, longint y);
      return ((box_reg[REG_BOX_MIN_X] <= x) == (x <= box_reg[REG_BOX_MAX_X])) &&
             ((box_reg[REG_BOX_MIN_Y] <= y) == (y <= box_reg[REG_BOX_MAX_Y]));
    endfunction

    function bit edge_hits_box(longint px, longint py, longint qx, longint qy);
      longint a, b;
      int s[4];
      longint cx[4];
      longint cy[4];
      a = py - qy;
      b = qx - px;
      cx = '{box_reg[REG_BOX_MIN_X], box_reg[REG_BOX_MIN_X],
             box_reg[REG_BOX_MAX_X], box_reg[REG_BOX_MAX_X]};
      cy = '{box_reg[REG_BOX_MIN_Y], box_reg[REG_BOX_MAX_Y],
             box_reg[REG_BOX_MAX_Y], box_reg[REG_BOX_MIN_Y]};
      foreach (s[i]) s[i] = line_sign(a, cx[i] - px, b, cy[i] - py);
      // All corners on one side of the line (or a degenerate edge): no contact.
      if (s[0] == s[1] && s[1] == s[2] && s[2] == s[3]) return 0;
      if (point_in_box(px, py) || point_in_box(qx, qy)) return 1;
      return ((px <= box_reg[REG_BOX_MAX_X]) == (box_reg[REG_BOX_MIN_X] <= qx)) &&
             ((py <= box_reg[REG_BOX_MAX_Y]) == (box_reg[REG_BOX_MIN_Y] <= qy));
    endfunction

    function void push_edge(longint px, longint py, longint qx, longint qy, bit closing);
      edge_result_t res;
      res.edge_index = IDX_BITS'(edge_count);
      res.touches = edge_hits_box(px, py, qx, qy);
      res.closing = closing;
      expected_edges.push_back(res);
      edge_count = (edge_count + 1) % MAX_EDGES;
    endfunction

    function void note_vertex(logic [COORD_BITS-1:0] xv, logic [COORD_BITS-1:0] yv,
                              bit is_last);
      longint x, y;
      x = longint'($signed(xv));
      y = longint'($signed(yv));
      if (!have_first) begin
        first_x = x;
        first_y = y;
        have_first = 1;
        edge_count = 0;
      end else begin
        push_edge(prev_x, prev_y, x, y, 0);
      end
      prev_x = x;
      prev_y = y;
      if (is_last) begin
        push_edge(x, y, first_x, first_y, 1);
        have_first = 0;
        edge_count = 0;
      end
    endfunction

    function void check_edge(realtime at, logic [IDX_BITS-1:0] idx, logic touches,
                             logic closing);
      edge_result_t exp_res;
      if (expected_edges.size() == 0) begin
        $display("[%0.3f ns] unexpected result word: edge_index %0d touches %0b last %0b",
                 at, idx, touches, closing);
        mismatches++;
        return;
      end
      exp_res = expected_edges.pop_front();
      if (idx !== exp_res.edge_index) begin
        $display("[%0.3f ns] edge_index: expected %0d, got %0d", at, exp_res.edge_index, idx);
        mismatches++;
      end
      if (touches !== exp_res.touches) begin
        $display("[%0.3f ns] touches_box (edge %0d): expected %0b, got %0b",
                 at, exp_res.edge_index, exp_res.touches, touches);
        mismatches++;
      end
      if (closing !== exp_res.closing) begin
        $display("[%0.3f ns] last_result (edge %0d): expected %0b, got %0b",
                 at, exp_res.edge_index, exp_res.closing, closing);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_edges.size();
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pebo_pkg::*;
  import pebo_tb_pkg::*;

  // An accepted vertex passes the edge, product and result registers to reach its
  // result word; after the last result, SETTLE_CYCLES pass before the box is touched.
  localparam int SETTLE_CYCLES = 8;
  // Length of the one long stall of the result side, counted by the receiver itself.
  localparam int HOLD_CYCLES   = 300;
  // Cycles with no word accepted on either side before the run is declared hung. The
  // longest legal quiet stretch is the long stall above plus one idle burst.
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 80;
  // Long enough for the edge counter to pass its top value and wrap.
  localparam int LONG_POLYGON  = 1030;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [COORD_BITS-1:0]    cfg_wdata;

  pebo_in_if  in_vtx ();
  pebo_out_if out_res ();

  polygon_edge_box_overlap u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vtx   (in_vtx),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  edge_touch_scoreboard sb = new();

  // Idling switches for both sides, and the request for the long result-side stall.
  bit sender_idles;
  bit receiver_idles;
  bit hold_req;
  int unsigned quiet_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Monitor. Both channels are sampled at the rising edge, before any of this edge's
  // nonblocking updates land, so every word is seen exactly as the block saw it. The
  // result side is checked first; a vertex accepted at this edge cannot have produced
  // a result yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        sb.check_edge($realtime, out_res.edge_index, out_res.touches_box,
                      out_res.last_result);
      end
      if (in_vtx.valid && in_vtx.ready) begin
        sb.note_vertex(in_vtx.vertex_x, in_vtx.vertex_y, in_vtx.last_vertex);
      end
      if ((out_res.valid && out_res.ready) || (in_vtx.valid && in_vtx.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result-side ready. Outside the long stall it either takes words or drops ready for a
  // random burst. Every branch ends on a clock edge, so ready gets at most one update per edge.
  initial begin
    out_res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one vertex word and returns at the edge where it is accepted. Valid stays high
  // on return so back-to-back words go out without a bubble; it only drops for an idle
  // burst or when the stream pauses.
  task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input bit is_last);
    if (sender_idles && $urandom_range(0, 9) == 0) begin
      in_vtx.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_vtx.valid       <= 1'b1;
    in_vtx.vertex_x    <= x;
    in_vtx.vertex_y    <= y;
    in_vtx.last_vertex <= is_last;
    @(posedge clk);
    while (!in_vtx.ready) @(posedge clk);
  endtask

  // Stops the vertex stream until every expected result word has come back, then lets the
  // pipeline settle. Also used before every box update, so the box only changes while the
  // block is idle. The first edge lets the monitor note the vertex taken at the edge on
  // which this task was entered.
  task automatic wait_quiet();
    in_vtx.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four box registers on consecutive edges; the write enable stays high across
  // them and drops once at the end.
  task automatic program_box(input logic signed [COORD_BITS-1:0] min_x,
                             input logic signed [COORD_BITS-1:0] min_y,
                             input logic signed [COORD_BITS-1:0] max_x,
                             input logic signed [COORD_BITS-1:0] max_y);
    cfg_reg_e              regs[4] = '{REG_BOX_MIN_X, REG_BOX_MIN_Y,
                                       REG_BOX_MAX_X, REG_BOX_MAX_Y};
    logic [COORD_BITS-1:0] vals[4];
    vals = '{min_x, min_y, max_x, max_y};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    logic [COORD_BITS-1:0] raw;
    raw = COORD_BITS'($urandom());
    return $signed(raw);
  endfunction

  // Picks a coordinate that lands near the current box most of the time, so that edges
  // cross, graze and miss it in useful proportions. The rest is full-range noise, the box
  // bounds themselves and their neighbours, and the extremes of the field.
  function automatic logic signed [COORD_BITS-1:0] pick_coord(longint bound_a,
                                                              longint bound_b);
    longint lo, hi, v;
    int     mode;
    lo = (bound_a < bound_b) ? bound_a : bound_b;
    hi = (bound_a < bound_b) ? bound_b : bound_a;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      v = lo - 64 + longint'($urandom_range(0, int'(hi - lo + 128)));
    end else if (mode <= 7) begin
      v = longint'(rand_coord());
    end else if (mode == 8) begin
      case ($urandom_range(0, 3))
        0: v = lo;
        1: v = hi;
        2: v = lo - 1;
        default: v = hi + 1;
      endcase
    end else begin
      v = $urandom_range(0, 1) ? -32768 : 32767;
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_x();
    return pick_coord(sb.box_reg[REG_BOX_MIN_X], sb.box_reg[REG_BOX_MAX_X]);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_y();
    return pick_coord(sb.box_reg[REG_BOX_MIN_Y], sb.box_reg[REG_BOX_MAX_Y]);
  endfunction

  // A well-formed polygon: random vertices near the box, now and then a repeated vertex
  // so that zero-length edges show up inside real polygons.
  task automatic send_polygon(input int n_verts);
    logic signed [COORD_BITS-1:0] x, y;
    x = 0;
    y = 0;
    for (int i = 0; i < n_verts; i++) begin
      if (i == 0 || $urandom_range(0, 7) != 0) begin
        x = pick_x();
        y = pick_y();
      end
      send_vertex(x, y, i == n_verts - 1);
    end
  endtask

  // Mostly whole polygons of one to eight vertices; the rest is loose vertices with a
  // random last flag, which breaks polygons off at odd points and leaves some open across
  // the next box change.
  task automatic run_phase(input int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
        send_polygon(n);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_vertex(pick_x(), pick_y(), 1'($urandom_range(0, 1)));
      end
      sent += n;
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_addr           <= REG_BOX_MIN_X;
    cfg_wdata          <= '0;
    in_vtx.valid       <= 1'b0;
    in_vtx.vertex_x    <= '0;
    in_vtx.vertex_y    <= '0;
    in_vtx.last_vertex <= 1'b0;
    sender_idles   = 0;
    receiver_idles = 0;
    hold_req       = 0;
    quiet_cycles   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words against the reset box, which is the single point at the origin.
    // A lone vertex marked last gives just the degenerate closing edge.
    send_vertex(5, 5, 1);
    // A triangle whose first edge runs straight through the origin.
    send_vertex(-1, -1, 0);
    send_vertex(1, 1, 0);
    send_vertex(-1, 1, 1);
    wait_quiet();

    program_box(-100, -100, 100, 100);
    // Two equal vertices: both edges have zero length.
    send_vertex(0, 0, 0);
    send_vertex(0, 0, 1);
    // The corners of the coordinate range, diagonals across the whole plane.
    send_vertex(-32768, -32768, 0);
    send_vertex(32767, 32767, 0);
    send_vertex(32767, -32768, 0);
    send_vertex(-32768, 32767, 1);
    // An edge that meets the box only at its upper right corner, then one that crosses the
    // box to its upper left corner; later a horizontal one stays clear above the box.
    send_vertex(100, 100, 0);
    send_vertex(200, 0, 0);
    send_vertex(-100, 100, 0);
    send_vertex(-200, 200, 0);
    send_vertex(200, 200, 1);
    wait_quiet();

    // Random part: a run of box settings, each held while the block is idle.
    sender_idles   = 1;
    receiver_idles = 1;
    program_box(-1000, -800, 1200, 900);
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // Ordered random box. The result side stalls for a long stretch at the start while
    // vertices keep coming, so the pipeline fills and the input side backs up.
    begin
      logic signed [COORD_BITS-1:0] a, b, c, d;
      a = rand_coord();
      b = rand_coord();
      c = rand_coord();
      d = rand_coord();
      program_box((a < b) ? a : b, (c < d) ? c : d, (a < b) ? b : a, (c < d) ? d : c);
    end
    hold_req = 1;
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // The whole plane, with one polygon long enough to wrap the edge counter. The long
    // polygon runs with no idling on either side.
    program_box(-32768, -32768, 32767, 32767);
    run_phase(PHASE_ITEMS / 2);
    sender_idles   = 0;
    receiver_idles = 0;
    send_polygon(LONG_POLYGON);
    sender_idles   = 1;
    receiver_idles = 1;
    run_phase(PHASE_ITEMS / 2);
    wait_quiet();

    // Inverted boxes: min above max on one or both axes.
    program_box(700, 300, -700, -300);
    run_phase(PHASE_ITEMS);
    wait_quiet();

    program_box(-32768, 32767, 32767, -32768);
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // Last part: a random, possibly inverted box and no idling at all.
    sender_idles   = 0;
    receiver_idles = 0;
    program_box(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    run_phase(PHASE_ITEMS);
    wait_quiet();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
